// ===== design/pms_pkg.sv =====
// ============================================================================
// pms_pkg - shared types and constants of the pwm melody sequencer
// Request and response payloads, configuration register codes, the
// controller to datapath command and status groups and the divider sizing.
// ============================================================================
`default_nettype none

package pms_pkg;

    // song table size and derived widths
    localparam int unsigned NOTES    = 64;
    localparam int unsigned NOTE_AW  = $clog2(NOTES);
    localparam int unsigned LEN_W    = 7;

    // timer clock and the fixed dividend of the top computation
    localparam int unsigned CLOCK_HZ = 16000000;
    localparam int unsigned DIVIDEND = CLOCK_HZ * 10 / 2;
    localparam int unsigned DIV_W    = $clog2(DIVIDEND + 1);
    localparam int unsigned DIV_CW   = $clog2(DIV_W);

    // configuration port
    localparam int unsigned CFG_DW   = 16;

    // reset values
    localparam logic [8:0]       VOLUME_RST   = 9'd0;
    localparam logic [LEN_W-1:0] SONG_LEN_RST = 7'd1;
    localparam logic [15:0]      IDLE_TOP_RST = 16'd320;
    localparam logic [2:0]       CH_EN_RST    = 3'd7;
    localparam logic [8:0]       VOLUME_FULL  = 9'd256;

    typedef enum logic [1:0] {
        CFG_VOLUME         = 2'd0,
        CFG_SONG_LENGTH    = 2'd1,
        CFG_IDLE_TOP       = 2'd2,
        CFG_CHANNEL_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  note_slot;
        logic [15:0] note_freq;
        logic [15:0] note_ms;
    } req_t;

    typedef struct packed {
        logic [15:0] top;
        logic [15:0] compare;
        logic [2:0]  channel_load;
        logic        counter_clear;
        logic        playing;
        logic [5:0]  note_pos;
        logic        song_done;
    } rsp_t;

    // one song table entry
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] ms;
    } note_t;

    typedef enum logic [1:0] {
        RD_POS  = 2'd0,
        RD_ZERO = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_CHECK  = 3'd1,
        ST_FETCH  = 3'd2,
        ST_DIVIDE = 3'd3,
        ST_SCALE  = 3'd4,
        ST_EMIT   = 3'd5
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    note_wr;
        logic    tick_inc;
        logic    restart;
        logic    stop;
        logic    finish;
        logic    advance;
        rd_sel_t rd_sel;
        logic    div_load;
        logic    div_step;
        logic    scale;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic expired;
        logic last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/pms_datapath.sv =====
// ============================================================================
// pms_datapath - song table, play state, top divider and response register
// Holds the note memory, position and elapsed count, the restoring divider
// that turns a note frequency into a timer top, the duty scaling and the
// configuration registers. Acts on commands from the controller.
// ============================================================================
`default_nettype none

module pms_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pms_pkg::req_t               req,
    input  logic                        rsp_ready,
    output pms_pkg::rsp_t               rsp,
    output logic                        rsp_valid,
    input  logic                        cfg_valid,
    input  pms_pkg::cfg_index_t         cfg_index,
    input  logic [pms_pkg::CFG_DW-1:0]  cfg_data,
    input  pms_pkg::dp_cmd_t            cmd,
    output pms_pkg::dp_status_t         status
);
    import pms_pkg::*;

    // configuration registers
    logic [8:0]        volume_reg;
    logic [LEN_W-1:0]  song_length_reg;
    logic [15:0]       idle_top_reg;
    logic [2:0]        channel_enable_reg;

    // play state
    logic              active_reg,   active_next;
    logic [NOTE_AW-1:0] position_reg, position_next;
    logic [15:0]       elapsed_reg,  elapsed_next;
    logic [15:0]       period_reg,   period_next;
    logic [15:0]       duty_reg,     duty_next;
    logic              loaded_reg,   loaded_next;
    logic              done_reg,     done_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    // divider
    logic [DIV_W-1:0]  dq_reg,      dq_next;
    logic [15:0]       rem_reg,     rem_next;
    logic [15:0]       divisor_reg;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;
    logic [16:0]       rem_shift;
    logic              rem_ge;

    // memory
    note_t             note_mem [NOTES];
    note_t             rd_data_reg;
    logic [NOTE_AW-1:0] rd_addr;

    logic [LEN_W-1:0]  pos_inc;
    logic [LEN_W-1:0]  len;
    logic [15:0]       top_sat;
    logic [8:0]        vol_sat;
    logic [24:0]       product;
    logic [15:0]       idle_top_safe;
    logic              slot_ok;

    assign pos_inc       = LEN_W'(position_reg) + LEN_W'(1);
    assign len           = (song_length_reg > LEN_W'(NOTES)) ? LEN_W'(NOTES)
                                                             : song_length_reg;
    assign slot_ok       = (LEN_W'(req.note_slot) < LEN_W'(NOTES));
    assign idle_top_safe = (idle_top_reg == 16'd0) ? 16'd1 : idle_top_reg;
    assign vol_sat       = (volume_reg > VOLUME_FULL) ? VOLUME_FULL : volume_reg;

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_NEXT: rd_addr = pos_inc[NOTE_AW-1:0];
            RD_POS:  rd_addr = position_reg;
            default: rd_addr = position_reg;
        endcase
    end

    // note memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.note_wr && slot_ok)
        begin
            note_mem[req.note_slot] <= '{freq: req.note_freq, ms: req.note_ms};
        end
        rd_data_reg <= note_mem[rd_addr];
    end

    // restoring divider step, one quotient bit per cycle
    assign rem_shift = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    always_comb
    begin
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_load)
        begin
            dq_next      = DIV_W'(DIVIDEND);
            rem_next     = '0;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dq_next      = {dq_reg[DIV_W-2:0], rem_ge};
            rem_next     = rem_ge ? 16'(rem_shift - {1'b0, divisor_reg})
                                  : rem_shift[15:0];
            div_cnt_next = div_cnt_reg + DIV_CW'(1);
        end
    end

    // saturate the quotient into the 16 bit top, then scale by volume
    assign top_sat = (|dq_reg[DIV_W-1:16]) ? 16'hFFFF
                   : ((dq_reg[15:0] == 16'd0) ? 16'd1 : dq_reg[15:0]);
    assign product = 25'(top_sat) * 25'(vol_sat);

    // play state update
    always_comb
    begin
        active_next   = active_reg;
        position_next = position_reg;
        elapsed_next  = elapsed_reg;
        period_next   = period_reg;
        duty_next     = duty_reg;
        loaded_next   = loaded_reg;
        done_next     = done_reg;

        if (cmd.accept)
        begin
            loaded_next = 1'b0;
            done_next   = 1'b0;
        end
        if (cmd.tick_inc && (elapsed_reg != 16'hFFFF))
        begin
            elapsed_next = elapsed_reg + 16'd1;
        end
        if (cmd.restart)
        begin
            active_next   = 1'b1;
            position_next = '0;
            loaded_next   = 1'b1;
        end
        if (cmd.advance)
        begin
            position_next = pos_inc[NOTE_AW-1:0];
            loaded_next   = 1'b1;
        end
        if (cmd.stop || cmd.finish)
        begin
            duty_next   = '0;
            period_next = idle_top_safe;
            active_next = 1'b0;
            loaded_next = 1'b1;
            done_next   = cmd.finish ? 1'b1 : active_reg;
        end
        if (cmd.div_load)
        begin
            elapsed_next = '0;
        end
        if (cmd.scale)
        begin
            period_next = top_sat;
            duty_next   = product[23:8];
        end
    end

    // response valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg         <= VOLUME_RST;
            song_length_reg    <= SONG_LEN_RST;
            idle_top_reg       <= IDLE_TOP_RST;
            channel_enable_reg <= CH_EN_RST;
            active_reg         <= 1'b0;
            position_reg       <= '0;
            elapsed_reg        <= '0;
            period_reg         <= IDLE_TOP_RST;
            duty_reg           <= '0;
            loaded_reg         <= 1'b0;
            done_reg           <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            div_cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_VOLUME:         volume_reg         <= cfg_data[8:0];
                    CFG_SONG_LENGTH:    song_length_reg    <= cfg_data[LEN_W-1:0];
                    CFG_IDLE_TOP:       idle_top_reg       <= cfg_data[15:0];
                    CFG_CHANNEL_ENABLE: channel_enable_reg <= cfg_data[2:0];
                    default:            volume_reg         <= volume_reg;
                endcase
            end
            active_reg    <= active_next;
            position_reg  <= position_next;
            elapsed_reg   <= elapsed_next;
            period_reg    <= period_next;
            duty_reg      <= duty_next;
            loaded_reg    <= loaded_next;
            done_reg      <= done_next;
            rsp_valid_reg <= rsp_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // divider and response payload registers
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (cmd.div_load)
        begin
            divisor_reg <= rd_data_reg.freq;
        end
        if (cmd.emit)
        begin
            rsp_reg.top           <= period_reg;
            rsp_reg.compare       <= duty_reg;
            rsp_reg.channel_load  <= loaded_reg ? channel_enable_reg : 3'd0;
            rsp_reg.counter_clear <= loaded_reg;
            rsp_reg.playing       <= active_reg;
            rsp_reg.note_pos      <= 6'(position_reg);
            rsp_reg.song_done     <= done_reg;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // status to the controller
    assign status.active   = active_reg;
    assign status.expired  = (elapsed_reg >= rd_data_reg.ms);
    assign status.last     = (pos_inc >= len);
    assign status.div_done = (div_cnt_reg == DIV_CW'(DIV_W - 1));
    assign status.out_free = !rsp_valid_reg || rsp_ready;

endmodule

`default_nettype wire

// ===== design/pms_ctrl.sv =====
// ============================================================================
// pms_ctrl - sequencing state machine of the pwm melody sequencer
// Takes one request at a time, steps the datapath through table lookup,
// note expiry check, top division and duty scaling, then posts the response.
// ============================================================================
`default_nettype none

module pms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pms_pkg::req_t       req,
    input  pms_pkg::dp_status_t status,
    output pms_pkg::dp_cmd_t    cmd
);
    import pms_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_POS;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (req.action)
                        ACT_TICK:
                        begin
                            if (status.active)
                            begin
                                cmd.tick_inc = 1'b1;
                                cmd.rd_sel   = RD_POS;
                                state_next   = ST_CHECK;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        ACT_WRITE:
                        begin
                            cmd.note_wr = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        ACT_START:
                        begin
                            cmd.restart = 1'b1;
                            cmd.rd_sel  = RD_ZERO;
                            state_next  = ST_FETCH;
                        end
                        ACT_STOP:
                        begin
                            cmd.stop   = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (!status.expired)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/pwm_melody_sequencer_top.sv =====
// ============================================================================
// pwm_melody_sequencer_top - melody sequencer for a phase-correct pwm timer
// Plays a table of notes by producing timer top and compare values.
// ============================================================================
// Usage:
//   req channel (valid/ready) carries one action: millisecond tick, note
//   write, song start or stop. Every request gives exactly one response on
//   the rsp channel (valid/ready) with the timer top, compare, channel load
//   mask, counter clear, playing flag, note position and song-done flag.
//   cfg channel (valid/ready, always ready) writes volume, song length,
//   idle top and channel enable; write it only while no request is open.
//   One request is in work at a time. A note write, a stop, an idle tick
//   or a tick that keeps the current note skips the divider. A start or a
//   tick that plays a new note reads the table, loads the restoring divider
//   that forms top at one quotient bit per cycle (27 steps at a 16 MHz
//   timer clock) and scales the duty before its response is posted.
//   The response sits in an output register; a new request is taken only
//   after it is posted, and a stalled receiver holds the sequencer in wait.
//   Reset returns to idle with top 320, compare 0 and the register resets;
//   the note table holds no defined contents until written.
// ============================================================================
`default_nettype none

module pwm_melody_sequencer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  pms_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output pms_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  pms_pkg::cfg_index_t         cfg_index,
    input  logic [pms_pkg::CFG_DW-1:0]  cfg_data
);
    import pms_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing control
    pms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .status    (status),
        .cmd       (cmd)
    );

    // table, divider and response datapath
    pms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== design/pms_checker.sv =====
// ============================================================================
// pms_port_checks - port level checks of the pwm melody sequencer
// Watches the request and response channels of the top level and is bound
// to it below.
// ============================================================================
`default_nettype none

module pms_port_checks (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pms_pkg::rsp_t rsp
);

    // a stalled response holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // one request in work: no new request straight after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in work");

    // compare never exceeds top, and top is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.compare <= rsp.top) && (rsp.top != 16'd0))
        else $error("compare above top or top zero");

    // song end always silences and clears the counter
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.song_done |-> !rsp.playing && rsp.counter_clear)
        else $error("song done without stop effects");

    // channels load only together with a counter clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.counter_clear |-> (rsp.channel_load == 3'd0))
        else $error("channel load without counter clear");

endmodule

bind pwm_melody_sequencer_top pms_port_checks u_checker (.*);

`default_nettype wire

// ===== sim/pms_checker.sv =====
// ============================================================================
// pms_checker - response checker for the pwm melody sequencer
// Watches the request, response and register write channels, keeps its own
// copy of the note table, song position and timer values, works out the
// response due for every accepted request and compares each accepted
// response against the oldest one still owed, field by field.
// ============================================================================

module pms_checker
    import pms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  req_t                req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  rsp_t                rsp,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  cfg_index_t          cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    output int unsigned         errors,
    output int unsigned         outstanding
);

    // shadow copy of the sequencer
    logic [15:0] freq_tab [0:NOTES-1];
    logic [15:0] ms_tab   [0:NOTES-1];
    logic        playing;
    logic [6:0]  pos;
    logic [15:0] elapsed;
    logic [15:0] period;
    logic [15:0] duty;

    // shadow registers
    logic [8:0]  volume;
    logic [6:0]  song_len;
    logic [15:0] idle_top;
    logic [2:0]  ch_en;

    rsp_t        owed_rsp [$];
    rsp_t        want;

    // timer top and compare for one note
    task automatic play_note(input logic [6:0] idx);
        logic [31:0] t;
        logic [31:0] v;
        logic [15:0] f;
        f = freq_tab[idx[5:0]];
        v = (volume > VOLUME_FULL) ? 32'(VOLUME_FULL) : 32'(volume);
        if (f == 16'd0)
            t = 32'd65535;
        else
            t = (CLOCK_HZ * 10) / (2 * 32'(f));
        if (t > 32'd65535)
            t = 32'd65535;
        if (t < 32'd1)
            t = 32'd1;
        period  = t[15:0];
        duty    = 16'((32'(period) * v) >> 8);
        elapsed = 16'd0;
    endtask

    // back to idle timer values
    task automatic go_silent();
        duty    = 16'd0;
        period  = (idle_top == 16'd0) ? 16'd1 : idle_top;
        playing = 1'b0;
    endtask

    // response owed for one request, updating the shadow state
    task automatic predict_response(input req_t r, output rsp_t e);
        logic        loaded;
        logic        done;
        logic [6:0]  len;
        logic [15:0] dur;
        loaded = 1'b0;
        done   = 1'b0;
        len    = (song_len > 7'(NOTES)) ? 7'(NOTES) : song_len;
        case (r.action)
            ACT_TICK:
            begin
                if (playing)
                begin
                    dur = ms_tab[pos[5:0]];
                    if (elapsed != 16'hFFFF)
                        elapsed = elapsed + 16'd1;
                    if (elapsed >= dur)
                    begin
                        pos    = pos + 7'd1;
                        loaded = 1'b1;
                        if (pos >= len)
                        begin
                            pos  = pos - 7'd1;
                            go_silent();
                            done = 1'b1;
                        end
                        else
                        begin
                            play_note(pos);
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                freq_tab[r.note_slot] = r.note_freq;
                ms_tab[r.note_slot]   = r.note_ms;
            end
            ACT_START:
            begin
                playing = 1'b1;
                pos     = 7'd0;
                play_note(7'd0);
                loaded  = 1'b1;
            end
            default:
            begin
                done   = playing;
                go_silent();
                loaded = 1'b1;
            end
        endcase
        e.top           = period;
        e.compare       = duty;
        e.channel_load  = loaded ? ch_en : 3'd0;
        e.counter_clear = loaded;
        e.playing       = playing;
        e.note_pos      = pos[5:0];
        e.song_done     = done;
    endtask

    task automatic check_field(input string fname, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
            errors++;
        end
    endtask

    // watch the channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NOTES; i++)
            begin
                freq_tab[i] = 16'd0;
                ms_tab[i]   = 16'd0;
            end
            playing  = 1'b0;
            pos      = 7'd0;
            elapsed  = 16'd0;
            period   = IDLE_TOP_RST;
            duty     = 16'd0;
            volume   = VOLUME_RST;
            song_len = SONG_LEN_RST;
            idle_top = IDLE_TOP_RST;
            ch_en    = CH_EN_RST;
            errors   = 0;
            owed_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            // responses against the oldest owed one
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("response with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("top", want.top, rsp.top);
                    check_field("compare", want.compare, rsp.compare);
                    check_field("channel_load", 16'(want.channel_load),
                                16'(rsp.channel_load));
                    check_field("counter_clear", 16'(want.counter_clear),
                                16'(rsp.counter_clear));
                    check_field("playing", 16'(want.playing), 16'(rsp.playing));
                    check_field("note_pos", 16'(want.note_pos), 16'(rsp.note_pos));
                    check_field("song_done", 16'(want.song_done),
                                16'(rsp.song_done));
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VOLUME:      volume   = cfg_data[8:0];
                    CFG_SONG_LENGTH: song_len = cfg_data[6:0];
                    CFG_IDLE_TOP:    idle_top = cfg_data[15:0];
                    default:         ch_en    = cfg_data[2:0];
                endcase
            end

            // accepted requests
            if (req_valid && req_ready)
            begin
                predict_response(req, want);
                owed_rsp.push_back(want);
            end

            outstanding <= owed_rsp.size();
        end
    end

endmodule

// ===== sim/tb_pwm_melody_sequencer_top.sv =====
// ============================================================================
// tb_pwm_melody_sequencer_top - testbench for the pwm melody sequencer
// Loads note tables, plays songs with millisecond ticks, restarts and stops
// them under several register settings, first in a short directed sequence
// and then in random songs with random gaps on both channels. A separate
// checker predicts every response; this module makes stimulus and reports.
// ============================================================================

module tb_pwm_melody_sequencer_top;

    import pms_pkg::*;

    localparam int unsigned TARGET_ITEMS = 1550;
    localparam int unsigned CALM_FROM    = 1300;
    localparam int unsigned MAX_BUDGET   = 120;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_index_t         cfg_index;
    logic [CFG_DW-1:0]  cfg_data;

    int unsigned        errors;
    int unsigned        outstanding;

    // stimulus bookkeeping
    logic               written [0:NOTES-1];
    logic [15:0]        slot_ms [0:NOTES-1];
    logic [6:0]         cur_len;
    int unsigned        n_items;
    int unsigned        n_songs;
    int unsigned        n_regs;
    bit                 gaps_on;
    logic               stall_on = 1'b0;
    int unsigned        stall_left = 0;

    pwm_melody_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pms_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls in random bursts while stall_on is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if (stall_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] rand_freq();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1, 2:    return 16'($urandom_range(1, 1220));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short notes, now and then a very long one
    function automatic logic [15:0] rand_ms();
        case ($urandom_range(0, 9))
            7, 8:    return 16'($urandom_range(4, 20));
            9:       return 16'($urandom);
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    // table slots that a song of the current length reads
    function automatic int song_need();
        if (cur_len == 7'd0)
            return 1;
        if (cur_len > 7'(NOTES))
            return NOTES;
        return int'(cur_len);
    endfunction

    // one request, with an optional gap before it
    task automatic send_item(input action_t act, input logic [5:0] slot,
                             input logic [15:0] freq, input logic [15:0] dur);
        req_t r;
        r.action    = act;
        r.note_slot = slot;
        r.note_freq = freq;
        r.note_ms   = dur;
        if (act == ACT_WRITE)
        begin
            written[slot] = 1'b1;
            slot_ms[slot] = dur;
        end
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        n_items++;
    endtask

    // request whose unused fields carry noise
    task automatic send_ctl(input action_t act);
        send_item(act, 6'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // let every owed response come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the registers selected by mask, only while idle
    task automatic write_regs(input logic [3:0] mask, input logic [15:0] vol,
                              input logic [15:0] len, input logic [15:0] itop,
                              input logic [15:0] chen);
        logic [15:0] vals [0:3];
        vals[CFG_VOLUME]         = vol;
        vals[CFG_SONG_LENGTH]    = len;
        vals[CFG_IDLE_TOP]       = itop;
        vals[CFG_CHANNEL_ENABLE] = chen;
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_index_t'(i);
                cfg_data  <= vals[i];
                do
                    @(posedge clk);
                while (!cfg_ready);
                if (cfg_index_t'(i) == CFG_SONG_LENGTH)
                    cur_len = vals[i][6:0];
                n_regs++;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_regs();
        logic [15:0] vol;
        logic [15:0] len;
        logic [15:0] itop;
        case ($urandom_range(0, 7))
            0, 1:    vol = 16'd0;
            2, 3:    vol = 16'd256;
            4:       vol = 16'($urandom_range(257, 511));
            default: vol = 16'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 19))
            0:       len = 16'd0;
            1:       len = 16'($urandom_range(7, 64));
            2:       len = 16'($urandom_range(64, 127));
            default: len = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       itop = 16'd0;
            1:       itop = 16'd1;
            2:       itop = 16'hFFFF;
            default: itop = 16'($urandom);
        endcase
        write_regs(4'($urandom_range(1, 15)), vol, len, itop,
                   16'($urandom_range(0, 7)));
    endtask

    // load the table the song needs, start it and tick through it
    task automatic random_song();
        int need;
        int budget;
        need = song_need();
        for (int i = 0; i < need; i++)
        begin
            if (!written[i] || $urandom_range(0, 3) == 0)
                send_item(ACT_WRITE, 6'(i), rand_freq(), rand_ms());
        end
        if ($urandom_range(0, 3) == 0)
            send_item(ACT_WRITE, 6'($urandom), rand_freq(), rand_ms());
        send_ctl(ACT_START);
        budget = $urandom_range(0, 3);
        for (int i = 0; i < need; i++)
            budget += ((slot_ms[i] > 16'd25) ? 25 : int'(slot_ms[i])) + 1;
        if (budget > MAX_BUDGET)
            budget = MAX_BUDGET;
        for (int k = 0; k < budget; k++)
        begin
            case ($urandom_range(0, 19))
                0:       send_ctl(ACT_STOP);
                1:       send_ctl(ACT_START);
                2:       send_item(ACT_WRITE, 6'($urandom), rand_freq(), rand_ms());
                default: send_ctl(ACT_TICK);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            send_ctl(ACT_STOP);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_VOLUME;
        cfg_data  <= '0;
        for (int i = 0; i < NOTES; i++)
        begin
            written[i] = 1'b0;
            slot_ms[i] = 16'd0;
        end
        cur_len = SONG_LEN_RST;
        n_items = 0;
        n_songs = 0;
        n_regs  = 0;
        gaps_on = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stop and tick while idle, zero frequency, zero duration
        send_ctl(ACT_STOP);
        send_ctl(ACT_TICK);
        send_item(ACT_WRITE, 6'd0, 16'd0, 16'd0);
        send_ctl(ACT_START);
        send_ctl(ACT_TICK);
        send_ctl(ACT_TICK);
        wait_idle();

        // full volume, idle top of zero, extreme table entries
        write_regs(4'hF, 16'd256, 16'd3, 16'd0, 16'd5);
        send_item(ACT_WRITE, 6'd1, 16'hFFFF, 16'd2);
        send_item(ACT_WRITE, 6'd2, 16'd1, 16'd1);
        send_item(ACT_WRITE, 6'd63, 16'h5555, 16'hFFFF);
        send_ctl(ACT_START);
        send_ctl(ACT_TICK);
        send_ctl(ACT_TICK);
        send_ctl(ACT_TICK);
        send_ctl(ACT_START);
        send_ctl(ACT_TICK);
        send_ctl(ACT_STOP);
        wait_idle();

        // volume above full scale, zero song length, widest idle top
        write_regs(4'hF, 16'd300, 16'd0, 16'hFFFF, 16'd0);
        send_ctl(ACT_START);
        send_ctl(ACT_TICK);
        send_item(ACT_WRITE, 6'd0, 16'd8000, 16'd3);
        send_ctl(ACT_START);
        send_ctl(ACT_STOP);
        wait_idle();
        write_regs(4'hF, 16'd128, 16'd2, 16'd320, 16'd7);

        // random songs, calm towards the end
        while (n_items < TARGET_ITEMS)
        begin
            if (n_items >= CALM_FROM)
            begin
                gaps_on = 1'b0;
                stall_on <= 1'b0;
            end
            else
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stall_on <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                random_regs();
            end
            random_song();
            n_songs++;
        end

        // drain and report
        wait_idle();
        repeat (40) @(posedge clk);
        $display("Summary: %0d requests in %0d random songs plus directed cases,",
                 n_items, n_songs);
        $display("         %0d register writes, %0d mismatches", n_regs, errors);
        if (outstanding != 0)
            $error("%0d responses never arrived", outstanding);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
